### sv/infix_integer_expression_evaluator_defines.svh
// Assertion macros used by the evaluator's top-level file.
`ifndef INFIX_INTEGER_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_INTEGER_EXPRESSION_EVALUATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define IIE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IIE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IIE_ASSERT(label, clk, rst_n, prop, msg)
`define IIE_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### sv/iie_pkg.sv
// Package with types, codes and helpers of the expression evaluator.
`default_nettype none
package iie_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned QueueDepth = 2;

	localparam logic [2:0] MODE_NUM = 3'd0;
	localparam logic [2:0] MODE_ADD = 3'd1;
	localparam logic [2:0] MODE_SUB = 3'd2;
	localparam logic [2:0] MODE_MUL = 3'd3;
	localparam logic [2:0] MODE_DIV = 3'd4;

	localparam logic [2:0] ERR_OK = 3'd0;
	localparam logic [2:0] ERR_DIV_ZERO = 3'd1;
	localparam logic [2:0] ERR_LEADING = 3'd2;
	localparam logic [2:0] ERR_DANGLING = 3'd3;
	localparam logic [2:0] ERR_EMPTY = 3'd4;

	// Action codes that the front end hands to the back end.
	localparam logic [2:0] ACT_NONE = 3'd0;
	localparam logic [2:0] ACT_LOAD = 3'd1;
	localparam logic [2:0] ACT_MUL = 3'd2;
	localparam logic [2:0] ACT_DIV = 3'd3;
	localparam logic [2:0] ACT_ADD = 3'd4;
	localparam logic [2:0] ACT_SUB = 3'd5;

	typedef struct packed {
		logic [2:0] mode;
		logic signed [31:0] number_value;
		logic line_end;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] expression_result;
		logic [2:0] error_code;
	} out_item_t;

	// One classified request for the back end.
	typedef struct packed {
		logic [2:0] act;
		logic [31:0] operand;
		logic last;
		logic [2:0] parse_err;
	} cmd_t;
endpackage
`default_nettype wire

### sv/iie_front.sv
// Front end: parses the token stream and issues arithmetic requests.
`default_nettype none
module iie_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire iie_pkg::in_item_t in_item,
	input wire logic in_valid,
	output logic in_ready,
	output iie_pkg::cmd_t cmd,
	output logic cmd_valid,
	input wire logic cmd_ready
);
	logic expect_q, seen_q;
	logic [2:0] perr_q;
	logic is_op, is_mulop;
	iie_pkg::cmd_t cmd_c;
	logic n_expect, n_seen;
	logic [2:0] n_perr;

	assign in_ready = cmd_ready;
	assign is_op = (in_item.mode == iie_pkg::MODE_ADD) || (in_item.mode == iie_pkg::MODE_SUB)
		|| (in_item.mode == iie_pkg::MODE_MUL) || (in_item.mode == iie_pkg::MODE_DIV);
	assign is_mulop = (in_item.mode == iie_pkg::MODE_MUL) || (in_item.mode == iie_pkg::MODE_DIV);

	// Classify the token against the parse state.
	always_comb begin
		n_expect = expect_q;
		n_seen = seen_q;
		n_perr = perr_q;
		cmd_c.act = iie_pkg::ACT_NONE;
		cmd_c.operand = in_item.number_value;
		cmd_c.last = in_item.line_end;
		if (perr_q == iie_pkg::ERR_OK) begin
			if (in_item.mode == iie_pkg::MODE_NUM) begin
				if (!expect_q) begin
					n_perr = iie_pkg::ERR_EMPTY;
				end else begin
					cmd_c.act = iie_pkg::ACT_LOAD;
					n_expect = 1'b0;
					n_seen = 1'b1;
				end
			end else if (is_op) begin
				if (!seen_q) begin
					n_perr = iie_pkg::ERR_LEADING;
				end else if (expect_q) begin
					n_perr = iie_pkg::ERR_DANGLING;
				end else begin
					n_expect = 1'b1;
					if (is_mulop) begin
						cmd_c.act = (in_item.mode == iie_pkg::MODE_MUL) ?
							iie_pkg::ACT_MUL : iie_pkg::ACT_DIV;
					end else begin
						cmd_c.act = (in_item.mode == iie_pkg::MODE_SUB) ?
							iie_pkg::ACT_SUB : iie_pkg::ACT_ADD;
					end
				end
			end
		end
		if (in_item.line_end && n_perr == iie_pkg::ERR_OK) begin
			if (!n_seen) begin
				n_perr = iie_pkg::ERR_EMPTY;
			end else if (n_expect) begin
				n_perr = iie_pkg::ERR_DANGLING;
			end
		end
		cmd_c.parse_err = n_perr;
	end

	assign cmd = cmd_c;
	assign cmd_valid = in_valid;

	// Parse state; cleared at the end of each line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= 1'b1;
			seen_q <= 1'b0;
			perr_q <= iie_pkg::ERR_OK;
		end else if (in_valid && cmd_ready) begin
			if (in_item.line_end) begin
				expect_q <= 1'b1;
				seen_q <= 1'b0;
				perr_q <= iie_pkg::ERR_OK;
			end else begin
				expect_q <= n_expect;
				seen_q <= n_seen;
				perr_q <= n_perr;
			end
		end
	end
endmodule
`default_nettype wire

### sv/iie_queue.sv
// Short request queue between front end and back end.
`default_nettype none
module iie_queue #(
	parameter int unsigned Depth = iie_pkg::QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire iie_pkg::cmd_t wr_data,
	input wire logic wr_valid,
	output logic wr_ready,
	output iie_pkg::cmd_t rd_data,
	output logic rd_valid,
	input wire logic rd_ready
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	iie_pkg::cmd_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = (cnt_q != Depth[AW:0]);
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	// Storage entries.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end
endmodule
`default_nettype wire

### sv/iie_back.sv
// Back end: term and sum arithmetic with a radix-2 divider and a result register.
`default_nettype none
module iie_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire iie_pkg::cmd_t cmd,
	input wire logic cmd_valid,
	output logic cmd_ready,
	output iie_pkg::out_item_t out_item,
	output logic out_valid,
	input wire logic out_ready
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_FIN = 2'd2;

	logic [1:0] state_q;
	logic [31:0] sum_q, term_q;
	logic neg_q;
	logic [1:0] pend_q;
	logic dz_q;
	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0] cnt_q;
	logic qneg_q, last_q;
	logic [2:0] perr_q;
	logic res_valid_q;
	iie_pkg::out_item_t res_q;
	logic [32:0] trial;
	logic [31:0] shifted_rem;
	logic take, out_free;
	logic [31:0] sum_fin;

	assign out_free = !res_valid_q || out_ready;
	// A request with a line end needs a free result slot.
	assign take = (state_q == ST_IDLE) && cmd_valid && (!cmd.last || out_free);
	assign cmd_ready = take;
	assign out_valid = res_valid_q;
	assign out_item = res_q;

	assign shifted_rem = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, shifted_rem} - {1'b0, den_q};
	assign sum_fin = neg_q ? (sum_q - term_q) : (sum_q + term_q);

	always_ff @(posedge clk) begin
		if (take) begin
			last_q <= cmd.last;
			perr_q <= cmd.parse_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q <= '0;
			term_q <= '0;
			neg_q <= 1'b0;
			pend_q <= 2'd0;
			dz_q <= 1'b0;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= '0;
			cnt_q <= '0;
			qneg_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (res_valid_q && out_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_FIN;
						case (cmd.act)
							iie_pkg::ACT_LOAD: begin
								pend_q <= 2'd0;
								if (pend_q == 2'd1) begin
									term_q <= term_q * cmd.operand;
								end else if (pend_q == 2'd2) begin
									if (cmd.operand == '0) begin
										dz_q <= 1'b1;
										term_q <= '0;
									end else begin
										den_q <= cmd.operand[31] ? -cmd.operand : cmd.operand;
										quo_q <= term_q[31] ? -term_q : term_q;
										rem_q <= '0;
										cnt_q <= 6'd32;
										qneg_q <= term_q[31] ^ cmd.operand[31];
										state_q <= ST_DIV;
									end
								end else begin
									term_q <= cmd.operand;
								end
							end
							iie_pkg::ACT_MUL: pend_q <= 2'd1;
							iie_pkg::ACT_DIV: pend_q <= 2'd2;
							iie_pkg::ACT_ADD, iie_pkg::ACT_SUB: begin
								sum_q <= sum_fin;
								term_q <= '0;
								neg_q <= (cmd.act == iie_pkg::ACT_SUB);
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					// One quotient bit per cycle, restoring.
					if (!trial[32]) begin
						rem_q <= trial[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= shifted_rem;
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 6'd1) begin
						state_q <= ST_FIN;
						term_q <= qneg_q ? -{quo_q[30:0], !trial[32]} : {quo_q[30:0], !trial[32]};
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					if (last_q) begin
						res_valid_q <= 1'b1;
						if (perr_q != iie_pkg::ERR_OK) begin
							res_q.error_code <= perr_q;
							res_q.expression_result <= '0;
						end else if (dz_q) begin
							res_q.error_code <= iie_pkg::ERR_DIV_ZERO;
							res_q.expression_result <= '0;
						end else begin
							res_q.error_code <= iie_pkg::ERR_OK;
							res_q.expression_result <= sum_fin;
						end
						sum_q <= '0;
						term_q <= '0;
						neg_q <= 1'b0;
						pend_q <= 2'd0;
						dz_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/infix_integer_expression_evaluator.sv
// Top level of the streaming infix expression evaluator.
// Input channel: a token (mode, number_value, line_end) is taken when push is
// high and full is low. Result channel: while empty is low, the value and
// error code of the oldest finished line are on result; pop takes it.
// A front end parses tokens and writes requests into a two-entry queue; a
// back end does the arithmetic, taking a request only when idle. Tokens pass
// its idle and finish states; a number after a divide also passes the divide
// state, where the radix-2 divider produces one quotient bit per cycle.
// Multiply is a single 32x32 step. A line's result is registered in the
// finish state after its last token; one further line end waits while a
// result is held unread. When the receiver stalls, the result register holds
// and the queue fills, after which full rises. Reset clears all line state,
// the queue and the result register; tokens are taken once reset is released.
`default_nettype none
`include "infix_integer_expression_evaluator_defines.svh"
module infix_integer_expression_evaluator #(
	parameter int unsigned QueueDepth = iie_pkg::QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire iie_pkg::in_item_t token,
	input wire logic push,
	output logic full,
	output iie_pkg::out_item_t result,
	output logic empty,
	input wire logic pop
);
	iie_pkg::cmd_t fcmd, qcmd;
	logic fvalid, fready, qvalid, qready, ovalid, in_ready;

	iie_front u_front (
		.clk(clk), .arst_n(arst_n), .in_item(token), .in_valid(push),
		.in_ready(in_ready), .cmd(fcmd), .cmd_valid(fvalid), .cmd_ready(fready)
	);

	iie_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr_data(fcmd), .wr_valid(fvalid),
		.wr_ready(fready), .rd_data(qcmd), .rd_valid(qvalid), .rd_ready(qready)
	);

	iie_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(qcmd), .cmd_valid(qvalid),
		.cmd_ready(qready), .out_item(result), .out_valid(ovalid), .out_ready(pop)
	);

	assign full = !in_ready;
	assign empty = !ovalid;

	`IIE_ASSERT(a_err_zero, clk, arst_n, (!empty && result.error_code != iie_pkg::ERR_OK) |-> (result.expression_result == '0), "errored line must give zero")
	`IIE_ASSERT(a_hold, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(result)), "held result changed")
	`IIE_ASSERT_NEVER(a_code, clk, arst_n, (!empty && result.error_code > iie_pkg::ERR_EMPTY), "bad error code")
endmodule
`default_nettype wire
